### hdl/odhm_pkg.sv
package odhm_pkg;

	typedef struct packed {
		logic signed [15:0] x_error;
		logic signed [15:0] y_error;
		logic signed [15:0] body_heading;
	} req_t;

	typedef struct packed {
		logic signed [15:0] duty_wheel_a;
		logic signed [15:0] duty_wheel_b;
		logic signed [15:0] duty_wheel_c;
		logic               drive_valid;
	} rsp_t;

	// datapath operations
	localparam logic [3:0] OP_WAIT  = 4'd0;
	localparam logic [3:0] OP_MULX  = 4'd1;
	localparam logic [3:0] OP_MIX   = 4'd2;
	localparam logic [3:0] OP_MAX   = 4'd3;
	localparam logic [3:0] OP_DINIT = 4'd4;
	localparam logic [3:0] OP_DSTEP = 4'd5;
	localparam logic [3:0] OP_DFIN  = 4'd6;
	localparam logic [3:0] OP_MULH  = 4'd7;
	localparam logic [3:0] OP_DEV   = 4'd8;
	localparam logic [3:0] OP_MULP  = 4'd9;
	localparam logic [3:0] OP_MULD  = 4'd10;
	localparam logic [3:0] OP_TERM  = 4'd11;
	localparam logic [3:0] OP_ADDT  = 4'd12;
	localparam logic [3:0] OP_OUT   = 4'd13;

	// sequencing conditions
	localparam logic [1:0] CND_NEXT   = 2'd0;
	localparam logic [1:0] CND_ALWAYS = 2'd1;
	localparam logic [1:0] CND_ZERO   = 2'd2;
	localparam logic [1:0] CND_DLOOP  = 2'd3;

	localparam int unsigned STEP_W = 5;

	typedef struct packed {
		logic [3:0]        op;
		logic [1:0]        cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic stall;
		logic zero;
		logic div_last;
	} stat_t;

	// 17 quotient bits: floor(|n| * 2^16 / max)
	localparam logic [4:0] DIV_LAST = 5'd16;

	localparam logic signed [27:0] COS30_Q15       = 28'sd28378;
	localparam logic signed [27:0] DEG_PER_RAD_Q20 = 28'sd60078979;

	localparam logic [15:0] P_GAIN_RST = 16'd144;
	localparam logic [15:0] D_GAIN_RST = 16'd21627;

	localparam logic REG_P_GAIN = 1'b0;
	localparam logic REG_D_GAIN = 1'b1;

	function automatic ctrl_t mk(input logic [3:0] op, input logic [1:0] cond,
		input logic [STEP_W-1:0] target);
		ctrl_t c;
		c.op     = op;
		c.cond   = cond;
		c.target = target;
		return c;
	endfunction

	// microprogram
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		unique case (step)
			5'd0:    c = mk(OP_WAIT,  CND_NEXT,   5'd0);
			5'd1:    c = mk(OP_MULX,  CND_NEXT,   5'd0);
			5'd2:    c = mk(OP_MIX,   CND_NEXT,   5'd0);
			5'd3:    c = mk(OP_MAX,   CND_NEXT,   5'd0);
			5'd4:    c = mk(OP_DINIT, CND_ZERO,   5'd7);
			5'd5:    c = mk(OP_DSTEP, CND_DLOOP,  5'd5);
			5'd6:    c = mk(OP_DFIN,  CND_NEXT,   5'd0);
			5'd7:    c = mk(OP_MULH,  CND_NEXT,   5'd0);
			5'd8:    c = mk(OP_DEV,   CND_NEXT,   5'd0);
			5'd9:    c = mk(OP_MULP,  CND_NEXT,   5'd0);
			5'd10:   c = mk(OP_MULD,  CND_NEXT,   5'd0);
			5'd11:   c = mk(OP_TERM,  CND_NEXT,   5'd0);
			5'd12:   c = mk(OP_ADDT,  CND_NEXT,   5'd0);
			5'd13:   c = mk(OP_MAX,   CND_NEXT,   5'd0);
			5'd14:   c = mk(OP_DINIT, CND_ZERO,   5'd17);
			5'd15:   c = mk(OP_DSTEP, CND_DLOOP,  5'd15);
			5'd16:   c = mk(OP_DFIN,  CND_NEXT,   5'd0);
			5'd17:   c = mk(OP_OUT,   CND_ALWAYS, 5'd0);
			default: c = mk(OP_WAIT,  CND_ALWAYS, 5'd0);
		endcase
		return c;
	endfunction

	// round(v / 2^16), ties away from zero
	function automatic logic signed [26:0] rnd_shr16(input logic signed [44:0] v);
		logic [44:0] mag;
		logic [44:0] r;
		mag = v[44] ? 45'(-v) : 45'(v);
		r   = (mag + 45'd32768) >> 16;
		return v[44] ? -$signed(r[26:0]) : $signed(r[26:0]);
	endfunction

	// round(v / 2^17), ties away from zero
	function automatic logic signed [27:0] rnd_shr17(input logic signed [45:0] v);
		logic [45:0] mag;
		logic [45:0] r;
		mag = v[45] ? 46'(-v) : 46'(v);
		r   = (mag + 46'd65536) >> 17;
		return v[45] ? -$signed(r[27:0]) : $signed(r[27:0]);
	endfunction

	function automatic logic [30:0] abs32(input logic signed [31:0] v);
		logic [31:0] m;
		m = v[31] ? 32'(-v) : 32'(v);
		return m[30:0];
	endfunction

endpackage

### hdl/omni_drive_heading_mixer.sv
// Three-wheel omni drive mixer with PD heading correction.
//
// Request channel (req_valid/req_ready/req): one control tick carrying the
// x and y position errors (mm) and the body heading (Q3.12 rad). Response
// channel (rsp_valid/rsp_ready/rsp): three wheel duties in Q1.15 plus
// drive_valid, which is low when the final maximum magnitude was zero.
// APB port: register 0 at 0x0 is the P gain, register 1 at 0x4 the D gain,
// both unsigned Q0.16 in bits 15:0; write only between requests.
//
// Each of the two normalizations runs three lanes of a 17-step restoring
// divider sharing the maximum as divisor, and is skipped when its maximum
// is zero. One request is worked at a time; the next is taken in the cycle
// after the result lands in the output register. The divider loop in the
// microprogram sets the rate.
//
// Reset clears the step counter, the output valid, the kept heading
// deviation and loads the default gains. If the receiver stalls, the
// finished response is held in the output register and the next request
// is still accepted and worked; the sequencer then waits at its last step.
module omni_drive_heading_mixer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  odhm_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output odhm_pkg::rsp_t  rsp,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import odhm_pkg::*;

	ctrl_t       ctrl;
	stat_t       stat;
	logic [15:0] p_gain;
	logic [15:0] d_gain;

	// gain registers
	odhm_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.p_gain  (p_gain),
		.d_gain  (d_gain)
	);

	// step counter and control store
	odhm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// shared multiplier, three divider lanes, output register
	odhm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.p_gain    (p_gain),
		.d_gain    (d_gain)
	);

endmodule

### hdl/odhm_apb.sv
module odhm_apb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] p_gain,
	output logic [15:0] d_gain
);
	import odhm_pkg::*;

	logic [15:0] p_gain_q;
	logic [15:0] d_gain_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q <= P_GAIN_RST;
			d_gain_q <= D_GAIN_RST;
		end else if (wr) begin
			if (paddr[2] == REG_P_GAIN) begin
				p_gain_q <= pwdata[15:0];
			end else begin
				d_gain_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_P_GAIN) ? {16'd0, p_gain_q} : {16'd0, d_gain_q};
	assign p_gain = p_gain_q;
	assign d_gain = d_gain_q;

endmodule

### hdl/odhm_seq.sv
module odhm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  odhm_pkg::stat_t stat,
	output odhm_pkg::ctrl_t ctrl
);
	import odhm_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [STEP_W-1:0] step_inc;

	assign ctrl     = ucode(step_q);
	assign step_inc = step_q + STEP_W'(1);

	always_comb begin
		if (stat.stall) begin
			step_d = step_q;
		end else begin
			unique case (ctrl.cond)
				CND_NEXT:   step_d = step_inc;
				CND_ALWAYS: step_d = ctrl.target;
				CND_ZERO:   step_d = stat.zero ? ctrl.target : step_inc;
				CND_DLOOP:  step_d = stat.div_last ? step_inc : ctrl.target;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

### hdl/odhm_dp.sv
module odhm_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  odhm_pkg::ctrl_t ctrl,
	output odhm_pkg::stat_t stat,
	input  logic            req_valid,
	output logic            req_ready,
	input  odhm_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output odhm_pkg::rsp_t  rsp,
	input  logic [15:0]     p_gain,
	input  logic [15:0]     d_gain
);
	import odhm_pkg::*;

	logic signed [15:0] x_q, y_q, h_q;
	logic signed [44:0] mul_q, acc_q;
	logic signed [31:0] w_q [3];
	logic        [30:0] mx_q;
	logic               zero_q;
	logic        [31:0] r_q [3];
	logic        [16:0] quo_q [3];
	logic               neg_q [3];
	logic        [4:0]  cnt_q;
	logic signed [26:0] dev_q, prev_q;
	logic signed [27:0] diff_q;
	logic signed [27:0] term_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic signed [16:0] mul_a;
	logic signed [27:0] mul_b;
	logic signed [44:0] mul_p;
	logic signed [31:0] ysh14, ysh15, mlo;
	logic        [30:0] a0, a1, a2, m01, mx;
	logic               fire, load_rsp;
	logic signed [45:0] term_sum;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		if (v > 32'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -32'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	assign req_ready = (ctrl.op == OP_WAIT);
	assign fire      = req_valid & req_ready;
	assign load_rsp  = (ctrl.op == OP_OUT) & (~rsp_valid_q | rsp_ready);

	assign stat.stall    = ((ctrl.op == OP_WAIT) & ~req_valid) |
	                       ((ctrl.op == OP_OUT) & rsp_valid_q & ~rsp_ready);
	assign stat.zero     = zero_q;
	assign stat.div_last = (cnt_q == DIV_LAST);

	// shared multiplier
	always_comb begin
		unique case (ctrl.op)
			OP_MULX: begin
				mul_a = 17'(x_q);
				mul_b = COS30_Q15;
			end
			OP_MULH: begin
				mul_a = 17'(h_q);
				mul_b = DEG_PER_RAD_Q20;
			end
			OP_MULP: begin
				mul_a = $signed({1'b0, p_gain});
				mul_b = 28'(dev_q);
			end
			OP_MULD: begin
				mul_a = $signed({1'b0, d_gain});
				mul_b = diff_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = 45'(mul_a) * 45'(mul_b);

	assign ysh14 = 32'(y_q) <<< 14;
	assign ysh15 = 32'(y_q) <<< 15;
	assign mlo   = $signed(mul_q[31:0]);

	assign a0  = abs32(w_q[0]);
	assign a1  = abs32(w_q[1]);
	assign a2  = abs32(w_q[2]);
	assign m01 = (a0 > a1) ? a0 : a1;
	assign mx  = (m01 > a2) ? m01 : a2;

	assign term_sum = 46'(acc_q) + 46'(mul_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			prev_q      <= '0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (ctrl.op == OP_MULD) begin
				prev_q <= dev_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic        ge;
		logic [31:0] rs;
		logic [16:0] qs;
		if (fire) begin
			x_q <= req.x_error;
			y_q <= req.y_error;
			h_q <= req.body_heading;
		end
		unique case (ctrl.op)
			OP_MULX, OP_MULH, OP_MULP: mul_q <= mul_p;
			OP_MULD: begin
				acc_q <= mul_q;
				mul_q <= mul_p;
			end
			default: ;
		endcase
		if (ctrl.op == OP_MULP) begin
			diff_q <= 28'(dev_q) - 28'(prev_q);
		end
		if (ctrl.op == OP_DEV) begin
			dev_q <= rnd_shr16(-mul_q);
		end
		if (ctrl.op == OP_TERM) begin
			term_q <= rnd_shr17(term_sum);
		end
		if (ctrl.op == OP_MAX) begin
			mx_q   <= mx;
			zero_q <= (mx == '0);
		end
		if (ctrl.op == OP_DINIT) begin
			cnt_q <= '0;
		end else if (ctrl.op == OP_DSTEP) begin
			cnt_q <= cnt_q + 5'd1;
		end
		for (int i = 0; i < 3; i++) begin
			ge = r_q[i] >= {1'b0, mx_q};
			rs = ge ? (r_q[i] - {1'b0, mx_q}) : r_q[i];
			qs = quo_q[i] + 17'd1;
			unique case (ctrl.op)
				OP_MIX: begin
					if (i == 0) begin
						w_q[i] <= mlo - ysh14;
					end else if (i == 1) begin
						w_q[i] <= ysh15;
					end else begin
						w_q[i] <= -mlo - ysh14;
					end
				end
				OP_DINIT: begin
					r_q[i]   <= {1'b0, abs32(w_q[i])};
					neg_q[i] <= w_q[i][31];
					quo_q[i] <= '0;
				end
				OP_DSTEP: begin
					quo_q[i] <= {quo_q[i][15:0], ge};
					r_q[i]   <= {rs[30:0], 1'b0};
				end
				OP_DFIN: begin
					// round half away: (floor(2|n|/d) + 1) / 2
					w_q[i] <= neg_q[i] ? -$signed({16'd0, qs[16:1]})
					                   : $signed({16'd0, qs[16:1]});
				end
				OP_ADDT: w_q[i] <= w_q[i] + 32'(term_q);
				default: ;
			endcase
		end
		if (load_rsp) begin
			rsp_q.duty_wheel_a <= sat16(w_q[0]);
			rsp_q.duty_wheel_b <= sat16(w_q[1]);
			rsp_q.duty_wheel_c <= sat16(w_q[2]);
			rsp_q.drive_valid  <= ~zero_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
